>>> rtl/core/xxh_pkg.sv
// xxh_pkg: shared constants, datapath op codes and controller/datapath
// command and status structs for the XXH32 stream core. No dependencies.
package xxh_pkg;

    localparam logic [31:0] P1 = 32'h9E37_79B1;
    localparam logic [31:0] P2 = 32'h85EB_CA77;
    localparam logic [31:0] P3 = 32'hC2B2_AE3D;
    localparam logic [31:0] P4 = 32'h27D4_EB2F;
    localparam logic [31:0] P5 = 32'h1656_67B1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LANE_MUL,
        OP_LANE_ROT,
        OP_LANE_WB,
        OP_MERGE,
        OP_ADDLEN,
        OP_WORD_MUL,
        OP_WORD_ROT,
        OP_WORD_WB,
        OP_TAIL_LOAD,
        OP_BYTE_MUL,
        OP_BYTE_ROT,
        OP_BYTE_WB,
        OP_AVAL1,
        OP_AVAL2,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic accept;   // input item taken this cycle
        t_op  op;       // datapath step
    } t_cmd;

    typedef struct packed {
        logic item_live;   // item carries a byte or ends the message
        logic item_last;
        logic stripe_done; // byte on the input completes a 16-byte stripe
        logic lane_last;   // lane round in progress is on lane 3
        logic words_left;
        logic bytes_left;
        logic out_free;    // output register can take a new hash
    } t_sts;

endpackage

>>> rtl/core/xxh_in_if.sv
// xxh_in_if: input channel, at most one message byte per item.
// Standalone; no package dependency.
interface xxh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

>>> rtl/core/xxh_out_if.sv
// xxh_out_if: result channel, one 32-bit hash per item.
// Standalone; no package dependency.
interface xxh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;

    modport source (output valid, hash, input ready);
    modport sink   (input valid, hash, output ready);
endinterface

>>> rtl/core/xxhash32_stream_core.sv
// xxhash32_stream_core: XXH32 of a byte stream, at most one byte per input item.
// Throughput: one byte per cycle while idle; a byte completing a stripe then runs four lane
// rounds. After the last item and any lane rounds, the core merges, adds the length, folds
// tail words, then tail bytes, avalanches and waits for a held hash; input closed till then.
// Reset: synchronous active-low i_rst_n clears seed, count and output valid; stripe is don't-care.
// Depends on xxh_pkg, xxh_in_if, xxh_out_if, xxh_ctrl, xxh_dp.
module xxhash32_stream_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xxh_in_if.sink       i_in,
    xxh_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);

    xxh_pkg::t_cmd w_cmd;
    xxh_pkg::t_sts w_sts;
    logic          w_in_ready;

    // Sequencer: takes bytes in its idle state, otherwise steps the datapath
    // through lane rounds and the finishing fold/avalanche.
    xxh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: stripe buffer as four words, four lanes, hash accumulator,
    // one 32x32 multiplier, and the output register that lets the next
    // message start while a hash waits.
    xxh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_data_byte  (i_in.data_byte),
        .i_byte_valid (i_in.byte_valid),
        .i_last       (i_in.last),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_hash       (o_out.hash)
    );

    assign i_in.ready = w_in_ready;

    // a last item always starts the finishing sequence
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.last |=> !i_in.ready)
        else $error("core still ready after last item");

    // a completed stripe always triggers the lane rounds
    a_stripe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && w_sts.stripe_done |=> !i_in.ready)
        else $error("no lane rounds after completed stripe");

    // a hash only appears from the finish step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.op == xxh_pkg::OP_DONE))
        else $error("output valid without finish");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == xxh_pkg::OP_DONE |=> o_out.valid)
        else $error("finish did not load output");

endmodule

>>> rtl/core/xxh_ctrl.sv
// xxh_ctrl: sequencer for the XXH32 core; issues at most one datapath op per cycle.
// Depends on xxh_pkg (t_op, t_cmd, t_sts).
module xxh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  xxh_pkg::t_sts i_sts,
    output xxh_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_ACCEPT,
        S_LMUL,
        S_LROT,
        S_LWB,
        S_MERGE,
        S_ADDLEN,
        S_WCHK,
        S_WMUL,
        S_WROT,
        S_WWB,
        S_TLOAD,
        S_BCHK,
        S_BMUL,
        S_BROT,
        S_BWB,
        S_AV1,
        S_AV2,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_fin;   // finish after the pending lane rounds
    logic   w_acc;

    assign o_in_ready = (r_state == S_ACCEPT);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.accept = w_acc;
        case (r_state)
            S_LMUL:  o_cmd.op = xxh_pkg::OP_LANE_MUL;
            S_LROT:  o_cmd.op = xxh_pkg::OP_LANE_ROT;
            S_LWB:   o_cmd.op = xxh_pkg::OP_LANE_WB;
            S_MERGE: o_cmd.op = xxh_pkg::OP_MERGE;
            S_ADDLEN: o_cmd.op = xxh_pkg::OP_ADDLEN;
            S_WMUL:  o_cmd.op = xxh_pkg::OP_WORD_MUL;
            S_WROT:  o_cmd.op = xxh_pkg::OP_WORD_ROT;
            S_WWB:   o_cmd.op = xxh_pkg::OP_WORD_WB;
            S_TLOAD: o_cmd.op = xxh_pkg::OP_TAIL_LOAD;
            S_BMUL:  o_cmd.op = xxh_pkg::OP_BYTE_MUL;
            S_BROT:  o_cmd.op = xxh_pkg::OP_BYTE_ROT;
            S_BWB:   o_cmd.op = xxh_pkg::OP_BYTE_WB;
            S_AV1:   o_cmd.op = xxh_pkg::OP_AVAL1;
            S_AV2:   o_cmd.op = xxh_pkg::OP_AVAL2;
            S_OUT:   o_cmd.op = i_sts.out_free ? xxh_pkg::OP_DONE : xxh_pkg::OP_NONE;
            default: o_cmd.op = xxh_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
            r_fin   <= 1'b0;
        end else begin
            case (r_state)
                S_ACCEPT: begin
                    if (w_acc && i_sts.item_live) begin
                        if (i_sts.stripe_done) begin
                            r_fin   <= i_sts.item_last;
                            r_state <= S_LMUL;
                        end else if (i_sts.item_last) begin
                            r_state <= S_MERGE;
                        end
                    end
                end
                S_LMUL:   r_state <= S_LROT;
                S_LROT:   r_state <= S_LWB;
                // four lane rounds, lane 0 to lane 3
                S_LWB: begin
                    if (!i_sts.lane_last) begin
                        r_state <= S_LMUL;
                    end else begin
                        r_state <= r_fin ? S_MERGE : S_ACCEPT;
                    end
                end
                S_MERGE:  r_state <= S_ADDLEN;
                S_ADDLEN: r_state <= S_WCHK;
                S_WCHK:   r_state <= i_sts.words_left ? S_WMUL : S_TLOAD;
                S_WMUL:   r_state <= S_WROT;
                S_WROT:   r_state <= S_WWB;
                S_WWB:    r_state <= S_WCHK;
                S_TLOAD:  r_state <= S_BCHK;
                S_BCHK:   r_state <= i_sts.bytes_left ? S_BMUL : S_AV1;
                S_BMUL:   r_state <= S_BROT;
                S_BROT:   r_state <= S_BWB;
                S_BWB:    r_state <= S_BCHK;
                S_AV1:    r_state <= S_AV2;
                S_AV2:    r_state <= S_OUT;
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_ACCEPT;
                    end
                end
                default:  r_state <= S_ACCEPT;
            endcase
        end
    end

endmodule

>>> rtl/core/xxh_dp.sv
// xxh_dp: XXH32 datapath - stripe words, lanes, hash accumulator, one shared
// 32x32 multiplier and the output register. Depends on xxh_pkg.
module xxh_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic [7:0]    i_data_byte,
    input  logic          i_byte_valid,
    input  logic          i_last,
    input  xxh_pkg::t_cmd i_cmd,
    output xxh_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [31:0]   o_hash
);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    logic [31:0] r_seed;
    logic [31:0] r_cnt;
    logic        r_big;
    logic        r_active;
    logic [1:0]  r_wleft;
    logic [1:0]  r_bleft;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic [31:0] r_word [4];
    logic [31:0] r_lane [4];
    logic [31:0] r_h;
    logic [31:0] r_mul;
    logic [31:0] r_tail;
    logic [1:0]  r_widx;

    logic [31:0] w_rword;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [31:0] w_prod;
    logic        w_take;
    logic        w_out_free;

    assign w_rword     = r_word[r_widx];
    assign w_take      = i_cmd.accept && (i_byte_valid || i_last);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_prod      = w_mul_a * w_mul_b;

    always_comb begin
        case (i_cmd.op)
            xxh_pkg::OP_LANE_MUL: begin w_mul_a = w_rword;                w_mul_b = xxh_pkg::P2; end
            xxh_pkg::OP_LANE_WB:  begin w_mul_a = r_h;                    w_mul_b = xxh_pkg::P1; end
            xxh_pkg::OP_WORD_MUL: begin w_mul_a = w_rword;                w_mul_b = xxh_pkg::P3; end
            xxh_pkg::OP_WORD_WB:  begin w_mul_a = r_h;                    w_mul_b = xxh_pkg::P4; end
            xxh_pkg::OP_BYTE_MUL: begin w_mul_a = {24'd0, r_tail[7:0]};   w_mul_b = xxh_pkg::P5; end
            xxh_pkg::OP_BYTE_WB:  begin w_mul_a = r_h;                    w_mul_b = xxh_pkg::P1; end
            xxh_pkg::OP_AVAL1:    begin w_mul_a = r_h ^ (r_h >> 15);      w_mul_b = xxh_pkg::P2; end
            xxh_pkg::OP_AVAL2:    begin w_mul_a = r_h ^ (r_h >> 13);      w_mul_b = xxh_pkg::P3; end
            default:              begin w_mul_a = '0;                     w_mul_b = '0;          end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_cnt       <= '0;
            r_big       <= 1'b0;
            r_active    <= 1'b0;
            r_wleft     <= '0;
            r_bleft     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                r_active <= 1'b1;
                if (i_byte_valid) begin
                    r_cnt <= r_cnt + 32'd1;
                    if (r_cnt[3:0] == 4'hF) begin
                        r_big <= 1'b1;
                    end
                end
            end
            case (i_cmd.op)
                xxh_pkg::OP_ADDLEN: begin
                    r_wleft <= r_cnt[3:2];
                    r_bleft <= r_cnt[1:0];
                end
                xxh_pkg::OP_WORD_WB: r_wleft <= r_wleft - 2'd1;
                xxh_pkg::OP_BYTE_WB: r_bleft <= r_bleft - 2'd1;
                xxh_pkg::OP_DONE: begin
                    r_out_valid <= 1'b1;
                    r_cnt       <= '0;
                    r_big       <= 1'b0;
                    r_active    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (!r_active) begin
                r_lane[0] <= r_seed + xxh_pkg::P1 + xxh_pkg::P2;
                r_lane[1] <= r_seed + xxh_pkg::P2;
                r_lane[2] <= r_seed;
                r_lane[3] <= r_seed - xxh_pkg::P1;
            end
            if (i_byte_valid) begin
                r_word[r_cnt[3:2]][{r_cnt[1:0], 3'b000} +: 8] <= i_data_byte;
                // full stripe: lane rounds run from lane 0
                if (r_cnt[3:0] == 4'hF) begin
                    r_widx <= '0;
                end
            end
        end
        case (i_cmd.op)
            xxh_pkg::OP_LANE_MUL: r_mul <= w_prod;
            xxh_pkg::OP_LANE_ROT: r_h <= rotl(r_lane[r_widx] + r_mul, 13);
            xxh_pkg::OP_LANE_WB: begin
                r_lane[r_widx] <= w_prod;
                r_widx         <= r_widx + 2'd1;
            end
            xxh_pkg::OP_MERGE: begin
                if (r_big) begin
                    r_h   <= rotl(r_lane[0], 1) + rotl(r_lane[1], 7);
                    r_mul <= rotl(r_lane[2], 12) + rotl(r_lane[3], 18);
                end else begin
                    r_h   <= r_lane[2] + xxh_pkg::P5;
                    r_mul <= '0;
                end
            end
            xxh_pkg::OP_ADDLEN: begin
                r_h    <= r_h + r_mul + r_cnt;
                r_widx <= '0;
            end
            xxh_pkg::OP_WORD_MUL: r_mul <= w_prod;
            xxh_pkg::OP_WORD_ROT: r_h <= rotl(r_h + r_mul, 17);
            xxh_pkg::OP_WORD_WB: begin
                r_h    <= w_prod;
                r_widx <= r_widx + 2'd1;
            end
            xxh_pkg::OP_TAIL_LOAD: r_tail <= w_rword;
            xxh_pkg::OP_BYTE_MUL: begin
                r_mul  <= w_prod;
                r_tail <= r_tail >> 8;
            end
            xxh_pkg::OP_BYTE_ROT: r_h <= rotl(r_h + r_mul, 11);
            xxh_pkg::OP_BYTE_WB:  r_h <= w_prod;
            xxh_pkg::OP_AVAL1:    r_h <= w_prod;
            xxh_pkg::OP_AVAL2:    r_h <= w_prod;
            xxh_pkg::OP_DONE:     r_out_hash <= r_h ^ (r_h >> 16);
            default: ;
        endcase
    end

    assign o_sts.item_live   = i_byte_valid || i_last;
    assign o_sts.item_last   = i_last;
    assign o_sts.stripe_done = i_byte_valid && (r_cnt[3:0] == 4'hF);
    assign o_sts.lane_last   = (r_widx == 2'd3);
    assign o_sts.words_left  = (r_wleft != 2'd0);
    assign o_sts.bytes_left  = (r_bleft != 2'd0);
    assign o_sts.out_free    = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_hash      = r_out_hash;

endmodule
